### src/grcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package grcs_pkg;

  // default storage limits
  localparam int MAX_ROWS_DEF = 1024;
  localparam int MAX_COLS_DEF = 256;

  // operation codes
  localparam logic [2:0] FUNC_LOAD_X    = 3'd0;
  localparam logic [2:0] FUNC_LOAD_RES  = 3'd1;
  localparam logic [2:0] FUNC_LOAD_COL  = 3'd2;
  localparam logic [2:0] FUNC_UPDATE    = 3'd3;
  localparam logic [2:0] FUNC_READ_RES  = 3'd4;
  localparam logic [2:0] FUNC_READ_COEF = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [1:0] STAT_BAD_DIV   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_ROWS      = 3'd0;
  localparam logic [2:0] REG_COLS      = 3'd1;
  localparam logic [2:0] REG_NOISE_VAR = 3'd2;
  localparam logic [2:0] REG_MIN_BETA  = 3'd3;
  localparam logic [2:0] REG_ETA       = 3'd4;

  // register reset values
  localparam logic [10:0] ROWS_RST      = 11'd1024;
  localparam logic [8:0]  COLS_RST      = 9'd256;
  localparam logic [30:0] NOISE_VAR_RST = 31'd65536;
  localparam logic [30:0] MIN_BETA_RST  = 31'd0;
  localparam logic [30:0] ETA_RST       = 31'd65536;

  // iterative units
  localparam logic [6:0]  DIV_STEPS     = 7'd64;
  localparam logic [48:0] SQRT_BIT_INIT = 49'h1_0000_0000_0000;
  localparam logic [63:0] TWO_POW_32    = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TWO_POW_48    = 64'h0001_0000_0000_0000;
  localparam logic [31:0] POS_LIMIT     = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT     = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]         func;
    logic [9:0]         row_index;
    logic [7:0]         col_index;
    logic signed [31:0] data_value;
    logic [30:0]        col_norm_in;
    logic [30:0]        prior_var_in;
    logic signed [31:0] noise_sample;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic signed [31:0] coef;
    logic [30:0]        norm;
    logic [30:0]        prior;
  } col_entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_RDWAIT, S_COLRD, S_T1MUL, S_T1GO, S_T1DIV, S_T2DIV,
    S_CSUM, S_PASS1, S_RHSMUL, S_RHSGO, S_RHSDIV, S_MEANDIV, S_SDDIV, S_SQRT,
    S_NOISE, S_BETA, S_PASS2, S_FIXB, S_FIN
  } state_e;

endpackage

`default_nettype wire

### src/gibbs_ridge_coefficient_sweep_unit.sv
// Gibbs column sweep for Bayesian ridge regression, signed Q16.16.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one item at a time;
// every item gives exactly one result on the output channel
// (out_valid_o/out_ready_i, out_item_o). Configuration is a plain write port.
// Loads go from dispatch to the final step; reads add a wait state for
// the registered memory read. In a column update each of its two row passes
// streams the matrix and residual memories one row per cycle through a short
// multiply pipeline, and in between one shared radix-2 divider runs five
// divisions and a 25-step square root unit forms the deviation.
// A new item is taken in the idle state even while the last result waits;
// a stalled receiver holds the finished result in the output register and
// the next item then waits in its final step until that register frees.
// Reset restores the register defaults and clears control state only;
// the stores hold nothing defined until loaded and get no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module gibbs_ridge_coefficient_sweep_unit #(
  parameter int MAX_ROWS = grcs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = grcs_pkg::MAX_COLS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire grcs_pkg::item_t  in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output grcs_pkg::result_t     out_item_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [30:0]      cfg_data_i
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -65'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  grcs_pkg::state_e state_q, state_d;

  // configuration registers
  logic [10:0] rows_q;
  logic [8:0]  cols_q;
  logic [30:0] nv_q, minb_q, eta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= grcs_pkg::ROWS_RST;
      cols_q <= grcs_pkg::COLS_RST;
      nv_q   <= grcs_pkg::NOISE_VAR_RST;
      minb_q <= grcs_pkg::MIN_BETA_RST;
      eta_q  <= grcs_pkg::ETA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        grcs_pkg::REG_ROWS:      rows_q <= cfg_data_i[10:0];
        grcs_pkg::REG_COLS:      cols_q <= cfg_data_i[8:0];
        grcs_pkg::REG_NOISE_VAR: nv_q   <= cfg_data_i;
        grcs_pkg::REG_MIN_BETA:  minb_q <= cfg_data_i;
        grcs_pkg::REG_ETA:       eta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes and index checks
  logic [10:0] eff_rows;
  logic [8:0]  eff_cols;
  grcs_pkg::item_t item_q;
  logic row_ok, col_ok;
  logic [RW-1:0] row_a;
  logic [CW-1:0] col_a;

  assign eff_rows = (32'(rows_q) < MAX_ROWS) ? rows_q : 11'(MAX_ROWS);
  assign eff_cols = (32'(cols_q) < MAX_COLS) ? cols_q : 9'(MAX_COLS);
  assign row_ok   = {1'b0, item_q.row_index} < eff_rows;
  assign col_ok   = {1'b0, item_q.col_index} < eff_cols;
  assign row_a    = RW'(item_q.row_index);
  assign col_a    = CW'(item_q.col_index);

  // datapath registers
  logic [10:0]        iss_q;
  logic               p1_v_q, p2_v_q, p3_v_q, p4_v_q;
  logic [RW-1:0]      p1_i_q, p2_i_q;
  logic signed [63:0] p2_prod_q, p4_prod_q;
  logic signed [31:0] p2_r_q, p2_x_q, p3_e_q, p3_x_q;
  logic signed [63:0] rhs_q;
  logic signed [31:0] old_beta_q, beta_q, mean_q;
  logic [30:0]        norm_q, prior_q, t1_q, t2_q, c_q;
  logic [63:0]        mul_q;
  logic signed [63:0] noise_prod_q;
  logic               sign_q;
  logic signed [31:0] res_val_q;
  logic [1:0]         res_st_q;
  logic               out_valid_q;
  grcs_pkg::result_t  out_item_q;

  // memories
  logic signed [31:0]   mat_mem [2**AW];
  logic signed [31:0]   res_mem [2**RW];
  grcs_pkg::col_entry_t col_mem [2**CW];
  logic signed [31:0]   mat_rd_q, res_rd_q;
  grcs_pkg::col_entry_t col_rd_q;

  logic                 mat_we, res_we, col_we;
  logic [AW-1:0]        mat_raddr;
  logic [RW-1:0]        res_raddr, res_waddr;
  logic signed [31:0]   res_wdata;
  grcs_pkg::col_entry_t col_wdata;

  // divider
  logic [30:0] dv_rem_q, dv_den_q;
  logic [63:0] dv_quo_q;
  logic [6:0]  dv_cnt_q;
  logic        dv_go;
  logic [63:0] dv_num;
  logic [30:0] dv_den;
  logic [31:0] rem_sh;
  logic        rem_ge;

  // square root
  logic [48:0] sq_v_q, sq_r_q, sq_bit_q, sq_t;

  // pass control
  logic               in_pass, issuing, pass_done;
  logic signed [31:0] mul_b;
  logic signed [63:0] p2_shift;
  logic signed [64:0] e_sum;
  logic signed [31:0] e_val;

  assign in_pass   = (state_q == grcs_pkg::S_PASS1) || (state_q == grcs_pkg::S_PASS2);
  assign issuing   = in_pass && (iss_q < eff_rows);
  assign pass_done = (iss_q == eff_rows) && !p1_v_q && !p2_v_q && !p3_v_q && !p4_v_q;
  assign mul_b     = (state_q == grcs_pkg::S_PASS1) ? old_beta_q : beta_q;
  assign p2_shift  = p2_prod_q >>> 16;
  assign e_sum     = (state_q == grcs_pkg::S_PASS1) ? (65'(p2_r_q) + 65'(p2_shift))
                                                    : (65'(p2_r_q) - 65'(p2_shift));
  assign e_val     = sat32(e_sum);

  // scalar helpers around the divider result
  logic [31:0]        q_lim, q_mag;
  logic signed [31:0] q_signed;
  logic [31:0]        c_sum;
  logic [30:0]        c_val;
  logic signed [31:0] rhs_s32;
  logic [31:0]        rhs_mag;
  logic [32:0]        beta_abs;
  logic signed [31:0] beta_fix;

  assign q_lim    = sign_q ? grcs_pkg::NEG_LIMIT : grcs_pkg::POS_LIMIT;
  assign q_mag    = (dv_quo_q > 64'(q_lim)) ? q_lim : dv_quo_q[31:0];
  assign q_signed = sign_q ? -$signed(q_mag) : $signed(q_mag);
  assign c_sum    = {1'b0, t1_q} + {1'b0, t2_q};
  assign c_val    = c_sum[31] ? 31'h7fff_ffff : c_sum[30:0];
  assign rhs_s32  = sat32(65'(rhs_q));
  assign rhs_mag  = rhs_s32[31] ? 32'(-rhs_s32) : 32'(rhs_s32);
  assign beta_abs = beta_q[31] ? -{beta_q[31], beta_q} : {1'b0, beta_q};
  assign beta_fix = (beta_abs < {2'b0, minb_q}) ? $signed({1'b0, minb_q}) : beta_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      grcs_pkg::S_IDLE:     if (in_valid_i) state_d = grcs_pkg::S_DISPATCH;
      grcs_pkg::S_DISPATCH: begin
        case (item_q.func)
          grcs_pkg::FUNC_UPDATE:
            state_d = col_ok ? grcs_pkg::S_COLRD : grcs_pkg::S_FIN;
          grcs_pkg::FUNC_READ_RES:
            state_d = row_ok ? grcs_pkg::S_RDWAIT : grcs_pkg::S_FIN;
          grcs_pkg::FUNC_READ_COEF:
            state_d = col_ok ? grcs_pkg::S_RDWAIT : grcs_pkg::S_FIN;
          default: state_d = grcs_pkg::S_FIN;
        endcase
      end
      grcs_pkg::S_RDWAIT: state_d = grcs_pkg::S_FIN;
      grcs_pkg::S_COLRD: begin
        if (nv_q == '0 || col_rd_q.prior == '0) state_d = grcs_pkg::S_FIN;
        else state_d = grcs_pkg::S_T1MUL;
      end
      grcs_pkg::S_T1MUL: state_d = grcs_pkg::S_T1GO;
      grcs_pkg::S_T1GO:  state_d = grcs_pkg::S_T1DIV;
      grcs_pkg::S_T1DIV: if (dv_cnt_q == '0) state_d = grcs_pkg::S_T2DIV;
      grcs_pkg::S_T2DIV: if (dv_cnt_q == '0) state_d = grcs_pkg::S_CSUM;
      grcs_pkg::S_CSUM:  state_d = (c_val == '0) ? grcs_pkg::S_FIN : grcs_pkg::S_PASS1;
      grcs_pkg::S_PASS1: if (pass_done) state_d = grcs_pkg::S_RHSMUL;
      grcs_pkg::S_RHSMUL: state_d = grcs_pkg::S_RHSGO;
      grcs_pkg::S_RHSGO:  state_d = grcs_pkg::S_RHSDIV;
      grcs_pkg::S_RHSDIV: if (dv_cnt_q == '0) state_d = grcs_pkg::S_MEANDIV;
      grcs_pkg::S_MEANDIV: if (dv_cnt_q == '0) state_d = grcs_pkg::S_SDDIV;
      grcs_pkg::S_SDDIV: if (dv_cnt_q == '0) state_d = grcs_pkg::S_SQRT;
      grcs_pkg::S_SQRT:  if (sq_bit_q == '0) state_d = grcs_pkg::S_NOISE;
      grcs_pkg::S_NOISE: state_d = grcs_pkg::S_BETA;
      grcs_pkg::S_BETA:  state_d = grcs_pkg::S_PASS2;
      grcs_pkg::S_PASS2: if (pass_done) state_d = grcs_pkg::S_FIXB;
      grcs_pkg::S_FIXB:  state_d = grcs_pkg::S_FIN;
      grcs_pkg::S_FIN:   if (!out_valid_q || out_ready_i) state_d = grcs_pkg::S_IDLE;
      default: state_d = grcs_pkg::S_IDLE;
    endcase
  end

  // memory controls and divider launch
  always_comb begin
    mat_we    = 1'b0;
    res_we    = 1'b0;
    col_we    = 1'b0;
    res_waddr = row_a;
    res_wdata = item_q.data_value;
    col_wdata = '{coef: item_q.data_value, norm: item_q.col_norm_in,
                  prior: item_q.prior_var_in};
    mat_raddr = {col_a, RW'(iss_q)};
    res_raddr = in_pass ? RW'(iss_q) : row_a;
    dv_go     = 1'b0;
    dv_num    = mul_q;
    dv_den    = nv_q;
    case (state_q)
      grcs_pkg::S_DISPATCH: begin
        case (item_q.func)
          grcs_pkg::FUNC_LOAD_X:   mat_we = row_ok && col_ok;
          grcs_pkg::FUNC_LOAD_RES: res_we = row_ok;
          grcs_pkg::FUNC_LOAD_COL: col_we = col_ok && (item_q.prior_var_in != '0);
          default: ;
        endcase
      end
      grcs_pkg::S_PASS1, grcs_pkg::S_PASS2: begin
        res_we    = p2_v_q;
        res_waddr = p2_i_q;
        res_wdata = e_val;
      end
      grcs_pkg::S_T1GO, grcs_pkg::S_RHSGO: dv_go = 1'b1;
      grcs_pkg::S_T1DIV: begin
        dv_go  = (dv_cnt_q == '0);
        dv_num = grcs_pkg::TWO_POW_32;
        dv_den = prior_q;
      end
      grcs_pkg::S_RHSDIV: begin
        dv_go  = (dv_cnt_q == '0);
        dv_num = {16'b0, q_mag, 16'b0};
        dv_den = c_q;
      end
      grcs_pkg::S_MEANDIV: begin
        dv_go  = (dv_cnt_q == '0);
        dv_num = grcs_pkg::TWO_POW_48;
        dv_den = c_q;
      end
      grcs_pkg::S_FIXB: begin
        col_we    = 1'b1;
        col_wdata = '{coef: beta_fix, norm: norm_q, prior: prior_q};
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (mat_we) mat_mem[{col_a, row_a}] <= item_q.data_value;
    mat_rd_q <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    res_rd_q <= res_mem[res_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_a] <= col_wdata;
    col_rd_q <= col_mem[col_a];
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {dv_rem_q, dv_quo_q[63]};
  assign rem_ge = rem_sh >= {1'b0, dv_den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_cnt_q <= '0;
    end else if (dv_go) begin
      dv_cnt_q <= grcs_pkg::DIV_STEPS;
    end else if (dv_cnt_q != '0) begin
      dv_cnt_q <= dv_cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_go) begin
      dv_rem_q <= '0;
      dv_quo_q <= dv_num;
      dv_den_q <= dv_den;
    end else if (dv_cnt_q != '0) begin
      dv_rem_q <= rem_ge ? 31'(rem_sh - {1'b0, dv_den_q}) : rem_sh[30:0];
      dv_quo_q <= {dv_quo_q[62:0], rem_ge};
    end
  end

  // integer square root, two radicand bits a step
  assign sq_t = sq_r_q + sq_bit_q;

  always_ff @(posedge clk_i) begin
    if (state_q == grcs_pkg::S_SDDIV && dv_cnt_q == '0) begin
      sq_v_q   <= dv_quo_q[48:0];
      sq_r_q   <= '0;
      sq_bit_q <= grcs_pkg::SQRT_BIT_INIT;
    end else if (state_q == grcs_pkg::S_SQRT && sq_bit_q != '0) begin
      if (sq_v_q >= sq_t) begin
        sq_v_q <= sq_v_q - sq_t;
        sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // row pass pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else begin
      p1_v_q <= issuing;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
    end
  end

  // row pass pipeline data
  always_ff @(posedge clk_i) begin
    p1_i_q    <= RW'(iss_q);
    p2_i_q    <= p1_i_q;
    p2_prod_q <= mul_b * mat_rd_q;
    p2_r_q    <= res_rd_q;
    p2_x_q    <= mat_rd_q;
    p3_e_q    <= e_val;
    p3_x_q    <= p2_x_q;
    p4_prod_q <= p3_e_q * p3_x_q;
  end

  // issue counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= '0;
    end else if (state_q == grcs_pkg::S_CSUM || state_q == grcs_pkg::S_BETA) begin
      iss_q <= '0;
    end else if (issuing) begin
      iss_q <= iss_q + 11'd1;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      grcs_pkg::S_IDLE: if (in_valid_i) item_q <= in_item_i;
      grcs_pkg::S_DISPATCH: begin
        res_val_q <= '0;
        res_st_q  <= grcs_pkg::STAT_OK;
        case (item_q.func)
          grcs_pkg::FUNC_LOAD_X:
            if (!(row_ok && col_ok)) res_st_q <= grcs_pkg::STAT_BAD_INDEX;
          grcs_pkg::FUNC_LOAD_RES, grcs_pkg::FUNC_READ_RES:
            if (!row_ok) res_st_q <= grcs_pkg::STAT_BAD_INDEX;
          grcs_pkg::FUNC_LOAD_COL: begin
            if (!col_ok) res_st_q <= grcs_pkg::STAT_BAD_INDEX;
            else if (item_q.prior_var_in == '0) res_st_q <= grcs_pkg::STAT_BAD_DIV;
          end
          grcs_pkg::FUNC_UPDATE, grcs_pkg::FUNC_READ_COEF:
            if (!col_ok) res_st_q <= grcs_pkg::STAT_BAD_INDEX;
          default: ;
        endcase
      end
      grcs_pkg::S_RDWAIT:
        res_val_q <= (item_q.func == grcs_pkg::FUNC_READ_RES) ? res_rd_q : col_rd_q.coef;
      grcs_pkg::S_COLRD: begin
        old_beta_q <= col_rd_q.coef;
        norm_q     <= col_rd_q.norm;
        prior_q    <= col_rd_q.prior;
        if (nv_q == '0 || col_rd_q.prior == '0) res_st_q <= grcs_pkg::STAT_BAD_DIV;
      end
      grcs_pkg::S_T1MUL: mul_q <= 64'(eta_q) * 64'(norm_q);
      grcs_pkg::S_T1DIV:
        if (dv_cnt_q == '0) begin
          t1_q <= (dv_quo_q > 64'(grcs_pkg::POS_LIMIT)) ? 31'h7fff_ffff : dv_quo_q[30:0];
        end
      grcs_pkg::S_T2DIV:
        if (dv_cnt_q == '0) begin
          t2_q <= (dv_quo_q > 64'(grcs_pkg::POS_LIMIT)) ? 31'h7fff_ffff : dv_quo_q[30:0];
        end
      grcs_pkg::S_CSUM: begin
        c_q   <= c_val;
        rhs_q <= '0;
        if (c_val == '0) res_st_q <= grcs_pkg::STAT_BAD_DIV;
      end
      grcs_pkg::S_PASS1: if (p4_v_q) rhs_q <= rhs_q + (p4_prod_q >>> 16);
      grcs_pkg::S_RHSMUL: begin
        sign_q <= rhs_s32[31];
        mul_q  <= 64'(eta_q) * 64'(rhs_mag);
      end
      grcs_pkg::S_MEANDIV: if (dv_cnt_q == '0) mean_q <= q_signed;
      grcs_pkg::S_NOISE:
        noise_prod_q <= $signed({8'b0, sq_r_q[24:0]}) * item_q.noise_sample;
      grcs_pkg::S_BETA:
        beta_q <= sat32(65'(mean_q) + 65'(noise_prod_q >>> 16));
      grcs_pkg::S_FIXB: res_val_q <= beta_fix;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == grcs_pkg::S_FIN && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == grcs_pkg::S_FIN && (!out_valid_q || out_ready_i)) begin
      out_item_q.result_value <= (res_st_q == grcs_pkg::STAT_OK) ? res_val_q : '0;
      out_item_q.status       <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= grcs_pkg::S_IDLE;
    else state_q <= state_d;
  end

  assign in_ready_o  = (state_q == grcs_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
